### design/rcbs_pkg.sv
// Shared types and fixed constants of the row center bin signature unit.
package rcbs_pkg;

  localparam int CFG_W     = 13;
  localparam int PIX_W     = 8;
  localparam int BIN_NUM_W = 5;
  localparam int ROW_NUM_W = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic take_byte;
    logic mean_start;
    logic setup_start;
    logic setup_load;
    logic out_load;
  } rcbs_cmd_t;

  typedef struct packed {
    logic cfg_write;
    logic bin_done;
    logic div_done;
    logic out_free;
  } rcbs_status_t;

endpackage

### design/row_center_bin_signature_unit.sv
// Row center bin signature unit: per-row center slice, binned into byte means.
// Input channel (in_valid_i / in_stall_o / pixel_byte_i) takes one channel
// byte per request in raster order. Bytes that do not finish a bin are taken
// at one per cycle while the input is not stalled. A byte that finishes a bin
// starts a restoring divide of the bin sum by the bin size; the divider
// retires one quotient bit per cycle over the dividend width (16 at the
// default parameters), and the input stalls from the edge that takes that
// byte until the quotient is loaded into the output register.
// Output channel (out_valid_o / out_stall_i) is a registered request; while
// the receiver stalls it holds, and bytes keep flowing until the next bin
// completes and its mean finds the register still full; the input then
// stalls until the register frees.
// Config channel (cfg_valid_i / cfg_ready_o) is always ready; a write to
// either register restarts the frame and recomputes the row geometry,
// stalling the input while the geometry setup runs after the write.
// Reset clears both registers, so bytes are dropped until a nonzero width
// and height with a wide enough slice are written.
module row_center_bin_signature_unit #(
  parameter int SIG_BINS  = 32,
  parameter int CHANNELS  = 3,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rcbs_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rcbs_pkg::PIX_W-1:0]      pixel_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcbs_pkg::PIX_W-1:0]      bin_mean_o,
  output logic [rcbs_pkg::BIN_NUM_W-1:0]  bin_number_o,
  output logic [rcbs_pkg::ROW_NUM_W-1:0]  row_number_o,
  output logic                            last_of_row_o,
  output logic                            last_of_frame_o
);
  import rcbs_pkg::*;

  rcbs_cmd_t    cmd;
  rcbs_status_t status;

  assign cfg_ready_o = 1'b1;

  rcbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rcbs_datapath #(
    .SIG_BINS  (SIG_BINS),
    .CHANNELS  (CHANNELS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pixel_byte_i    (pixel_byte_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .bin_mean_o      (bin_mean_o),
    .bin_number_o    (bin_number_o),
    .row_number_o    (row_number_o),
    .last_of_row_o   (last_of_row_o),
    .last_of_frame_o (last_of_frame_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mean_start |=> in_stall_o)
    else $error("input not stalled while a bin mean is divided");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (status.div_done && status.out_free))
    else $error("output loaded before quotient ready or register free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mean_start |=> !status.div_done)
    else $error("divider did not restart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mean_start |-> (cmd.take_byte && !cmd.setup_start))
    else $error("mean divide started without a byte");

endmodule

### design/rcbs_divider.sv
// Restoring divider, one quotient bit per cycle.
module rcbs_divider #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    div_q, div_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DW:0]      shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = done_q;
    shifted = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(NW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d = DW'(shifted - {1'b0, div_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = DW'(shifted);
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/rcbs_datapath.sv
// Datapath: registers, row and bin counters, accumulator, divider, output register.
module rcbs_datapath #(
  parameter int SIG_BINS  = 32,
  parameter int CHANNELS  = 3,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [rcbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rcbs_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [rcbs_pkg::PIX_W-1:0]         pixel_byte_i,
  input  logic                               out_stall_i,
  input  rcbs_pkg::rcbs_cmd_t                cmd_i,
  output rcbs_pkg::rcbs_status_t             status_o,
  output logic                               out_valid_o,
  output logic [rcbs_pkg::PIX_W-1:0]         bin_mean_o,
  output logic [rcbs_pkg::BIN_NUM_W-1:0]     bin_number_o,
  output logic [rcbs_pkg::ROW_NUM_W-1:0]     row_number_o,
  output logic                               last_of_row_o,
  output logic                               last_of_frame_o
);
  import rcbs_pkg::*;

  localparam int WMAX          = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int SLICE_MAX     = WMAX / 2 + 2;
  localparam int BIN_PIX_MAX   = SLICE_MAX / SIG_BINS;
  localparam int BB_MAX        = BIN_PIX_MAX * CHANNELS;
  localparam int ACC_MAX       = 255 * BB_MAX;
  localparam int ROW_BYTES_MAX = WMAX * CHANNELS;
  localparam int BPX_W         = $clog2(BIN_PIX_MAX + 1);
  localparam int BB_W          = $clog2(BB_MAX + 1);
  localparam int ACC_W         = $clog2(ACC_MAX + 1);
  localparam int POS_W         = $clog2(ROW_BYTES_MAX + 1);
  localparam int BIN_W         = $clog2(SIG_BINS + 1);
  // Reciprocal gives the exact floor of slice / SIG_BINS for any CFG_W-bit slice.
  localparam int RCP_SHIFT     = CFG_W + $clog2(SIG_BINS);
  localparam int RCP_MULT      = ((1 << RCP_SHIFT) + SIG_BINS - 1) / SIG_BINS;
  localparam int RCP_W         = RCP_SHIFT + CFG_W;
  localparam int DIV_NW        = ACC_W;
  localparam int DIV_DW        = BB_W;

  logic [CFG_W-1:0]  width_q, height_q;
  logic [CFG_W-1:0]  w_clamp, slice;
  logic [RCP_W-1:0]  recip_prod;
  logic              active_q;
  logic [BPX_W-1:0]  bin_pix_q;
  logic [BB_W-1:0]   bin_size_q;
  logic [POS_W-1:0]  first_byte_q, end_byte_q, row_bytes_q;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CFG_W-1:0]  row_q, row_d;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [BB_W-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  acc_sum;
  logic              in_slice, bin_done, row_wrap;

  logic [BIN_W-1:0]  pend_bin_q;
  logic [CFG_W-1:0]  pend_row_q;
  logic              pend_last_row_q, pend_last_frame_q;
  logic              last_row;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_dividend, div_quo;
  logic [DIV_DW-1:0] div_divisor;

  logic              out_valid_q;

  // Widths above the supported maximum behave as the maximum.
  assign w_clamp    = (width_q > CFG_W'(WMAX)) ? CFG_W'(WMAX) : width_q;
  assign slice      = w_clamp - {w_clamp[CFG_W-1:2], 1'b0};
  assign recip_prod = RCP_W'(slice) * RCP_W'(RCP_MULT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
      endcase
    end
  end

  // Geometry derived once per configuration change.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      bin_pix_q    <= '0;
      bin_size_q   <= '0;
      first_byte_q <= '0;
      end_byte_q   <= '0;
      row_bytes_q  <= '0;
    end else if (cfg_valid_i) begin
      active_q <= 1'b0;
    end else if (cmd_i.setup_start) begin
      bin_pix_q <= BPX_W'(recip_prod >> RCP_SHIFT);
    end else if (cmd_i.setup_load) begin
      active_q     <= (w_clamp != '0) && (height_q != '0) &&
                      (slice >= CFG_W'(SIG_BINS));
      bin_size_q   <= BB_W'(bin_pix_q * CHANNELS);
      first_byte_q <= POS_W'(w_clamp[CFG_W-1:2] * CHANNELS);
      end_byte_q   <= POS_W'(w_clamp[CFG_W-1:2] * CHANNELS +
                             bin_pix_q * (SIG_BINS * CHANNELS));
      row_bytes_q  <= POS_W'(w_clamp * CHANNELS);
    end
  end

  assign acc_sum  = acc_q + ACC_W'(pixel_byte_i);
  assign in_slice = (pos_q >= first_byte_q) && (pos_q < end_byte_q);
  assign bin_done = active_q && in_slice &&
                    ({1'b0, cnt_q} + 1'b1 >= {1'b0, bin_size_q});
  assign row_wrap = ({1'b0, pos_q} + 1'b1) >= {1'b0, row_bytes_q};

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    bin_d = bin_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    if (cfg_valid_i) begin
      pos_d = '0;
      row_d = '0;
      bin_d = '0;
      cnt_d = '0;
      acc_d = '0;
    end else if (cmd_i.take_byte && active_q) begin
      if (in_slice) begin
        if (bin_done) begin
          acc_d = '0;
          cnt_d = '0;
          bin_d = bin_q + 1'b1;
        end else begin
          acc_d = acc_sum;
          cnt_d = cnt_q + 1'b1;
        end
      end
      if (row_wrap) begin
        pos_d = '0;
        bin_d = '0;
        cnt_d = '0;
        acc_d = '0;
        row_d = ((row_q + 1'b1) >= height_q) ? '0 : row_q + 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      row_q <= '0;
      bin_q <= '0;
      cnt_q <= '0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      row_q <= row_d;
      bin_q <= bin_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  assign last_row = (bin_q == BIN_W'(SIG_BINS - 1));

  // Hold the bin's tags while its mean is divided out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_start) begin
      pend_bin_q        <= bin_q;
      pend_row_q        <= row_q;
      pend_last_row_q   <= last_row;
      pend_last_frame_q <= last_row && (row_q == height_q - 1'b1);
    end
  end

  assign div_start    = cmd_i.mean_start;
  assign div_dividend = DIV_NW'(acc_sum);
  assign div_divisor  = DIV_DW'(bin_size_q);

  rcbs_divider #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_mean_o      <= PIX_W'(div_quo);
      bin_number_o    <= BIN_NUM_W'(pend_bin_q);
      row_number_o    <= ROW_NUM_W'(pend_row_q);
      last_of_row_o   <= pend_last_row_q;
      last_of_frame_o <= pend_last_frame_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.cfg_write = cfg_valid_i;
  assign status_o.bin_done  = bin_done;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

### design/rcbs_ctrl.sv
// Controller: sequences setup, byte intake and mean division.
module rcbs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  rcbs_pkg::rcbs_status_t status_i,
  output rcbs_pkg::rcbs_cmd_t    cmd_o,
  output logic                   in_stall_o
);
  import rcbs_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_CFG   = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_MEAN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (status_i.cfg_write) begin
      state_d = ST_CFG;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (in_valid_i) begin
            cmd_o.take_byte = 1'b1;
            if (status_i.bin_done) begin
              cmd_o.mean_start = 1'b1;
              state_d          = ST_MEAN;
            end
          end
        end
        ST_CFG: begin
          cmd_o.setup_start = 1'b1;
          state_d           = ST_SETUP;
        end
        ST_SETUP: begin
          cmd_o.setup_load = 1'b1;
          state_d          = ST_RUN;
        end
        ST_MEAN: begin
          // Wait for the quotient and a free output register.
          if (status_i.div_done && status_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_RUN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_RUN);

endmodule

### tb/sv/tb_row_center_bin_signature_unit.sv
`timescale 1ns / 1ps
// Testbench for the row center bin signature unit, checked against a bin-mean predictor.
module tb_row_center_bin_signature_unit;
  import rcbs_pkg::*;

  localparam int SIG_BINS         = 32;
  localparam int CHANNELS         = 3;
  localparam int MAX_WIDTH        = 4096;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT      = 3000;
  localparam int PHASE_BYTES      = 190;

  typedef struct packed {
    logic [PIX_W-1:0]     mean;
    logic [BIN_NUM_W-1:0] bin_num;
    logic [ROW_NUM_W-1:0] row_num;
    logic                 last_row;
    logic                 last_frame;
  } bin_result_t;

  typedef enum int {BYTES_RANDOM, BYTES_FULL, BYTES_EMPTY, BYTES_EXTREME} byte_style_e;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     bin_mean_o;
  logic [BIN_NUM_W-1:0] bin_number_o;
  logic [ROW_NUM_W-1:0] row_number_o;
  logic                 last_of_row_o;
  logic                 last_of_frame_o;

  logic [PIX_W-1:0] pixel_queue[$];
  bin_result_t      expected_bins[$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_requests = 0;
  int               holds_served = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;
  int               fault_count = 0;

  // Predicted register contents and row walk
  int unsigned cfg_width = 0;
  int unsigned cfg_height = 0;
  int unsigned sig_byte_pos = 0;
  int unsigned sig_row = 0;
  int unsigned sig_bin = 0;
  int unsigned sig_bin_fill = 0;
  int unsigned sig_bin_sum = 0;

  row_center_bin_signature_unit #(
    .SIG_BINS (SIG_BINS),
    .CHANNELS (CHANNELS),
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_byte_i   (pixel_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bin_mean_o     (bin_mean_o),
    .bin_number_o   (bin_number_o),
    .row_number_o   (row_number_o),
    .last_of_row_o  (last_of_row_o),
    .last_of_frame_o(last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void restart_frame();
    sig_byte_pos = 0;
    sig_row      = 0;
    sig_bin      = 0;
    sig_bin_fill = 0;
    sig_bin_sum  = 0;
  endfunction

  // Fold one byte into the current bin; return 1 when the bin closes.
  function automatic bit fold_pixel_byte(input logic [PIX_W-1:0] pix, output bin_result_t res);
    int unsigned w, h, x_begin, slice, bin_size, first_byte, end_byte, row_bytes;
    bit closed;
    closed = 1'b0;
    res = '0;
    w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h = cfg_height;
    if (w == 0 || h == 0) return 1'b0;
    x_begin = w / 4;
    slice = w - 2 * x_begin;
    if (slice < SIG_BINS) return 1'b0;
    bin_size   = (slice / SIG_BINS) * CHANNELS;
    first_byte = x_begin * CHANNELS;
    end_byte   = first_byte + SIG_BINS * bin_size;
    row_bytes  = w * CHANNELS;
    if (sig_byte_pos >= first_byte && sig_byte_pos < end_byte) begin
      sig_bin_sum += pix;
      sig_bin_fill++;
      if (sig_bin_fill >= bin_size) begin
        res.mean       = PIX_W'(sig_bin_sum / bin_size);
        res.bin_num    = BIN_NUM_W'(sig_bin);
        res.row_num    = ROW_NUM_W'(sig_row);
        res.last_row   = (sig_bin == SIG_BINS - 1);
        res.last_frame = res.last_row && (sig_row == h - 1);
        closed = 1'b1;
        sig_bin_sum  = 0;
        sig_bin_fill = 0;
        sig_bin++;
      end
    end
    sig_byte_pos++;
    if (sig_byte_pos >= row_bytes) begin
      sig_byte_pos = 0;
      sig_bin      = 0;
      sig_bin_fill = 0;
      sig_bin_sum  = 0;
      sig_row++;
      if (sig_row >= h) sig_row = 0;
    end
    return closed;
  endfunction

  // Sender: offer the next queued byte once the current request is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        pixel_byte_i <= pixel_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or one long hold when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD_CYCLES;
      out_stall_i  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Track register writes and accepted bytes
  always @(posedge clk_i) begin
    bin_result_t res;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) begin
          cfg_width = cfg_wdata_i;
        end else begin
          cfg_height = cfg_wdata_i;
        end
        restart_frame();
      end
      if (in_valid_i && !in_stall_o && fold_pixel_byte(pixel_byte_i, res)) begin
        expected_bins.push_back(res);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bins.size() == 0) begin
        $error("bin with no request pending: mean %0d, bin %0d, row %0d",
               bin_mean_o, bin_number_o, row_number_o);
        fault_count++;
      end else begin
        want = expected_bins.pop_front();
        check_field("bin_mean", want.mean, bin_mean_o);
        check_field("bin_number", want.bin_num, bin_number_o);
        check_field("row_number", want.row_num, row_number_o);
        check_field("last_of_row", want.last_row, last_of_row_o);
        check_field("last_of_frame", want.last_frame, last_of_frame_o);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_pixels(input int count);
    byte_style_e style;
    style = BYTES_RANDOM;
    for (int i = 0; i < count; i++) begin
      // Switch style every 24 bytes so some bins are all 0 or all 255
      if (i % 24 == 0) begin
        case ($urandom_range(7))
          0: style = BYTES_FULL;
          1: style = BYTES_EMPTY;
          2: style = BYTES_EXTREME;
          default: style = BYTES_RANDOM;
        endcase
      end
      case (style)
        BYTES_FULL:    pixel_queue.push_back(8'hFF);
        BYTES_EMPTY:   pixel_queue.push_back(8'h00);
        BYTES_EXTREME: pixel_queue.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        default:       pixel_queue.push_back(PIX_W'($urandom_range(255)));
      endcase
    end
  endtask

  // Wait until every byte is taken and every bin has come out, then idle for a settle period
  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_valid_i || expected_bins.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input int w, input int h);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
  endtask

  initial begin
    int w, h;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty image right after reset, then zero height, zero width, narrow slice
    queue_pixels(3);
    configure(62, 0);
    queue_pixels(3);
    configure(0, 5);
    queue_pixels(3);
    configure(61, 2);
    queue_pixels(3);
    // Oversized width and height; bytes still ahead of the slice
    configure(8191, 8191);
    queue_pixels(6);

    w = 62;
    h = 1;
    for (int p = 0; p < 6; p++) begin
      // Phase 3 rewrites the same values to check the restart alone
      if (p != 3) begin
        w = ($urandom_range(3) == 0) ? $urandom_range(62, 140) : $urandom_range(62, 70);
        h = $urandom_range(1, 2);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      configure(w, h);
      if (p == 1) begin
        // Pause the sender mid-row until every bin is out
        queue_pixels(PHASE_BYTES / 2);
        wait_drained();
        queue_pixels(PHASE_BYTES - PHASE_BYTES / 2);
      end else begin
        queue_pixels(PHASE_BYTES);
        if (p == 4) hold_requests++;
      end
    end

    // Widest row again, with bytes still short of the slice
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    configure(8191, 2);
    queue_pixels(24);

    wait_drained();
    if (fault_count == 0 && expected_bins.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
